// File: rtl/core/cfti_pkg.sv
`default_nettype none
package cfti_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD_POINT = 2'd0;
   localparam logic [1:0] REQ_LOAD_FIELD = 2'd1;
   localparam logic [1:0] REQ_QUERY      = 2'd2;

   // register index of the CSR block
   localparam int CSR_TABLE_VALID = 0;

   // table geometry that does not vary
   localparam int SENSOR_CNT     = 5;
   localparam int NUM_AXES       = 3;
   localparam int VALS_PER_POINT = SENSOR_CNT * NUM_AXES;
   localparam int FRAC_BITS      = 16;

   // controller to datapath commands
   typedef struct packed {
      logic wr_point;
      logic wr_field;
      logic cap_query;
      logic rd_first;
      logic rd_last;
      logic cap_c0;
      logic cap_cn;
      logic pick_first;
      logic pick_last;
      logic srch_init;
      logic srch_rd;
      logic srch_step;
      logic srch_done;
      logic pick_upper;
      logic div_step;
      logic emit_init;
      logic emit_step;
   } cfti_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic zero;
      logic below;
      logic above;
      logic gt;
      logic at_end;
      logic num_ge_den;
      logic div_done;
      logic emit_done;
   } cfti_stat_type;

endpackage
`default_nettype wire

// File: rtl/core/cfti_ctrl.sv
`default_nettype none
module cfti_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            req_type,
   input  wire cfti_pkg::cfti_stat_type stat,
   output cfti_pkg::cfti_cmd_type     cmd,
   output logic                       busy
);
   import cfti_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD0  = 4'd1;
   localparam logic [3:0] ST_RD1  = 4'd2;
   localparam logic [3:0] ST_CLMP = 4'd3;
   localparam logic [3:0] ST_DEC  = 4'd4;
   localparam logic [3:0] ST_SRD  = 4'd5;
   localparam logic [3:0] ST_SCMP = 4'd6;
   localparam logic [3:0] ST_DCHK = 4'd7;
   localparam logic [3:0] ST_DIV  = 4'd8;
   localparam logic [3:0] ST_EI   = 4'd9;
   localparam logic [3:0] ST_EMIT = 4'd10;
   localparam logic [3:0] ST_DR1  = 4'd11;
   localparam logic [3:0] ST_DR2  = 4'd12;

   logic [3:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_LOAD_POINT: cmd.wr_point = 1'b1;
                  REQ_LOAD_FIELD: cmd.wr_field = 1'b1;
                  REQ_QUERY: begin
                     cmd.cap_query = 1'b1;
                     state_in      = ST_RD0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD0: begin
            cmd.rd_first = 1'b1;
            state_in     = ST_RD1;
         end
         ST_RD1: begin
            cmd.cap_c0  = 1'b1;
            cmd.rd_last = 1'b1;
            state_in    = ST_CLMP;
         end
         ST_CLMP: begin
            cmd.cap_cn = 1'b1;
            state_in   = ST_DEC;
         end
         ST_DEC: begin
            if (stat.zero || stat.below) begin
               cmd.pick_first = 1'b1;
               state_in       = ST_EI;
            end else if (stat.above) begin
               cmd.pick_last = 1'b1;
               state_in      = ST_EI;
            end else begin
               cmd.srch_init = 1'b1;
               state_in      = ST_SRD;
            end
         end
         ST_SRD: begin
            cmd.srch_rd = 1'b1;
            state_in    = ST_SCMP;
         end
         ST_SCMP: begin
            if (stat.gt && !stat.at_end) begin
               cmd.srch_step = 1'b1;
               state_in      = ST_SRD;
            end else begin
               cmd.srch_done = 1'b1;
               state_in      = ST_DCHK;
            end
         end
         ST_DCHK: begin
            if (stat.num_ge_den) begin
               cmd.pick_upper = 1'b1;
               state_in       = ST_EI;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = ST_EI;
         end
         ST_EI: begin
            cmd.emit_init = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (stat.emit_done) state_in = ST_DR1;
         end
         // let the result pipeline finish before query state may change
         ST_DR1: state_in = ST_DR2;
         ST_DR2: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// File: rtl/core/cfti_datapath.sv
`default_nettype none
module cfti_datapath #(
   parameter int COIL_CNT    = 8,
   parameter int POINT_CNT   = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfti_pkg::cfti_cmd_type cmd,
   output cfti_pkg::cfti_stat_type     stat,
   input  wire logic                   table_valid,
   input  wire logic [2:0]             req_coil_index,
   input  wire logic [3:0]             req_point_index,
   input  wire logic [2:0]             req_sensor_index,
   input  wire logic [1:0]             req_axis_index,
   input  wire logic signed [15:0]     req_load_value,
   input  wire logic signed [15:0]     req_query_current,
   output logic                        rsp_strobe,
   output logic [2:0]                  rsp_out_sensor,
   output logic [1:0]                  rsp_out_axis,
   output logic signed [15:0]          rsp_field_value,
   output logic                        rsp_last_of_run
);
   import cfti_pkg::*;

   localparam int PW  = (POINT_CNT > 1) ? $clog2(POINT_CNT) : 1;
   localparam int FD  = COIL_CNT * POINT_CNT * VALS_PER_POINT;
   localparam int FAW = $clog2(FD);
   localparam int VW  = VALUE_WIDTH;
   localparam int PRW = VW + 18;
   localparam logic [PW-1:0] LAST_POINT = PW'(POINT_CNT - 1);
   localparam logic [3:0]    LAST_K     = 4'(VALS_PER_POINT - 1);
   localparam logic [2:0]    LAST_S     = 3'(SENSOR_CNT - 1);
   localparam logic [1:0]    LAST_A     = 2'(NUM_AXES - 1);

   // memories
   logic signed [15:0]   bp_mem [POINT_CNT];
   logic signed [VW-1:0] fld_mem [FD];

   logic signed [15:0]   bp_q;
   logic signed [VW-1:0] v0_q, v1_q;

   // query state
   logic [2:0]           coil_ff;
   logic signed [15:0]   cur_ff, c0_ff, cn_ff, prev_ff;
   logic                 zero_ff, interp_ff;
   logic [PW-1:0]        j_ff, lo_ff, hi_ff;
   logic [17:0]          rem_ff, den_ff;
   logic [15:0]          t_ff;
   logic [3:0]           div_cnt_ff;
   logic [FAW-1:0]       addr0_ff, addr1_ff;
   logic [3:0]           k_ff;
   logic [2:0]           s_ff;
   logic [1:0]           a_ff;

   // result pipeline
   logic                 s1_valid_ff, s2_valid_ff;
   logic [2:0]           s1_sensor_ff, s2_sensor_ff;
   logic [1:0]           s1_axis_ff, s2_axis_ff;
   logic                 s1_last_ff, s2_last_ff;
   logic signed [PRW-1:0] prod_ff;
   logic signed [VW-1:0] v0_s2_ff;

   logic                 pt_ok, fld_ok;
   logic [FAW-1:0]       fld_wa;
   logic [PW-1:0]        bp_ra;
   logic signed [15:0]   clamp_lo, clamp_hi;
   logic signed [17:0]   num_w, den_w;
   logic [17:0]          rem_sh;
   logic signed [VW:0]   diff;
   logic signed [PRW-1:0] sum;
   logic signed [PRW-1:0] res;

   // load decode
   assign pt_ok  = 32'(req_point_index) < POINT_CNT;
   assign fld_ok = pt_ok && (32'(req_coil_index) < COIL_CNT)
                 && (32'(req_sensor_index) < SENSOR_CNT)
                 && (32'(req_axis_index) < NUM_AXES);
   assign fld_wa = FAW'((32'(req_coil_index) * POINT_CNT + 32'(req_point_index))
                        * VALS_PER_POINT + 32'(req_sensor_index) * NUM_AXES
                        + 32'(req_axis_index));

   // breakpoint memory, one read port
   always_comb begin
      if (cmd.rd_first)     bp_ra = '0;
      else if (cmd.rd_last) bp_ra = LAST_POINT;
      else                  bp_ra = j_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_point && pt_ok) bp_mem[PW'(req_point_index)] <= req_load_value;
      if (cmd.rd_first || cmd.rd_last || cmd.srch_rd) bp_q <= bp_mem[bp_ra];
   end

   // field memory, two read ports
   always_ff @(posedge clock) begin
      if (cmd.wr_field && fld_ok) fld_mem[fld_wa] <= VW'(req_load_value);
      if (cmd.emit_step) begin
         v0_q <= fld_mem[addr0_ff + FAW'(k_ff)];
         v1_q <= fld_mem[addr1_ff + FAW'(k_ff)];
      end
   end

   // clamp against first and last breakpoint
   assign clamp_lo = (cur_ff < c0_ff) ? c0_ff : cur_ff;
   assign clamp_hi = (clamp_lo > bp_q) ? bp_q : clamp_lo;

   assign num_w  = 18'(cur_ff) - 18'(prev_ff);
   assign den_w  = 18'(bp_q) - 18'(prev_ff);
   assign rem_sh = {rem_ff[16:0], 1'b0};

   // query capture, search and divide
   always_ff @(posedge clock) begin
      if (cmd.cap_query) begin
         coil_ff <= req_coil_index;
         cur_ff  <= req_query_current;
         zero_ff <= !table_valid || (32'(req_coil_index) >= COIL_CNT);
      end
      if (cmd.cap_c0) c0_ff <= bp_q;
      if (cmd.cap_cn) begin
         cn_ff  <= bp_q;
         cur_ff <= clamp_hi;
      end
      if (cmd.pick_first) begin
         lo_ff     <= '0;
         interp_ff <= 1'b0;
      end
      if (cmd.pick_last) begin
         lo_ff     <= LAST_POINT;
         interp_ff <= 1'b0;
      end
      if (cmd.srch_init) begin
         j_ff    <= PW'(1);
         prev_ff <= c0_ff;
      end
      if (cmd.srch_step) begin
         j_ff    <= j_ff + PW'(1);
         prev_ff <= bp_q;
      end
      if (cmd.srch_done) begin
         lo_ff      <= j_ff - PW'(1);
         hi_ff      <= j_ff;
         rem_ff     <= 18'(num_w);
         den_ff     <= 18'(den_w);
         interp_ff  <= 1'b1;
         t_ff       <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.pick_upper) begin
         lo_ff     <= hi_ff;
         interp_ff <= 1'b0;
      end
      // restoring divide, one quotient bit a cycle
      if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 4'd1;
         if (rem_sh >= den_ff) begin
            rem_ff <= rem_sh - den_ff;
            t_ff   <= {t_ff[14:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            t_ff   <= {t_ff[14:0], 1'b0};
         end
      end
      if (cmd.emit_init) begin
         addr0_ff <= FAW'((32'(coil_ff) * POINT_CNT + 32'(lo_ff)) * VALS_PER_POINT);
         addr1_ff <= FAW'((32'(coil_ff) * POINT_CNT + 32'(hi_ff)) * VALS_PER_POINT);
      end
   end

   // emit counters
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         s_ff <= '0;
         a_ff <= '0;
      end else if (cmd.emit_init) begin
         k_ff <= '0;
         s_ff <= '0;
         a_ff <= '0;
      end else if (cmd.emit_step) begin
         k_ff <= k_ff + 4'd1;
         if (a_ff == LAST_A) begin
            a_ff <= '0;
            s_ff <= s_ff + 3'd1;
         end else begin
            a_ff <= a_ff + 2'd1;
         end
      end
   end

   // status
   assign stat.zero       = zero_ff;
   assign stat.below      = cur_ff <= c0_ff;
   assign stat.above      = cur_ff >= cn_ff;
   assign stat.gt         = cur_ff > bp_q;
   assign stat.at_end     = j_ff == LAST_POINT;
   assign stat.num_ge_den = rem_ff >= den_ff;
   assign stat.div_done   = div_cnt_ff == 4'd15;
   assign stat.emit_done  = k_ff == LAST_K;

   // pipeline: read, multiply, add
   assign diff = {v1_q[VW-1], v1_q} - {v0_q[VW-1], v0_q};
   assign sum  = PRW'(v0_s2_ff) + (prod_ff >>> FRAC_BITS);

   always_comb begin
      if (zero_ff)        res = '0;
      else if (interp_ff) res = sum;
      else                res = PRW'(v0_s2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.emit_step;
         s2_valid_ff <= s1_valid_ff;
         rsp_strobe  <= s2_valid_ff;
      end
      s1_sensor_ff    <= s_ff;
      s1_axis_ff      <= a_ff;
      s1_last_ff      <= (k_ff == LAST_K) && (s_ff == LAST_S);
      s2_sensor_ff    <= s1_sensor_ff;
      s2_axis_ff      <= s1_axis_ff;
      s2_last_ff      <= s1_last_ff;
      prod_ff         <= diff * $signed({1'b0, t_ff});
      v0_s2_ff        <= v0_q;
      rsp_out_sensor  <= s2_sensor_ff;
      rsp_out_axis    <= s2_axis_ff;
      rsp_last_of_run <= s2_last_ff;
      rsp_field_value <= 16'(res);
   end

endmodule
`default_nettype wire

// File: rtl/core/coil_field_table_interpolator_top.sv
`default_nettype none
// Coil field table interpolator. Load words (breakpoint or field) are taken
// while busy is low and give no result. A query holds busy high while it runs.
// One that lands at or beyond the table ends (or finds the table not valid)
// skips the search and the divide; any other query runs the segment search
// through the single breakpoint read port, then the bit-serial divider for
// the fraction where it is needed, and streams the results out of the
// dual-read field memory. The 15 result words follow in back-to-back cycles,
// sensor-major, each shown for exactly one cycle on rsp_strobe; the receiver
// has to take them as they come. The last word shows in the first cycle after
// busy has dropped. Write table_valid only while no query is in flight.
module coil_field_table_interpolator_top #(
   parameter int COIL_CNT    = 8,
   parameter int POINT_CNT   = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic [2:0]         req_coil_index,
   input  wire logic [3:0]         req_point_index,
   input  wire logic [2:0]         req_sensor_index,
   input  wire logic [1:0]         req_axis_index,
   input  wire logic signed [15:0] req_load_value,
   input  wire logic signed [15:0] req_query_current,
   output logic                    rsp_strobe,
   output logic [2:0]              rsp_out_sensor,
   output logic [1:0]              rsp_out_axis,
   output logic signed [15:0]      rsp_field_value,
   output logic                    rsp_last_of_run,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import cfti_pkg::*;

   cfti_cmd_type  cmd;
   cfti_stat_type stat;
   logic          accept;
   logic          table_valid_ff;
   logic          csr_wr;

   assign accept = start && !busy;

   // CSR block
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_valid_ff <= 1'b0;
      end else if (csr_wr && (32'(csr_paddr[2]) == CSR_TABLE_VALID)) begin
         table_valid_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (32'(csr_paddr[2]) == CSR_TABLE_VALID) ?
                       {31'b0, table_valid_ff} : 32'b0;

   cfti_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   cfti_datapath #(
      .COIL_CNT    (COIL_CNT),
      .POINT_CNT   (POINT_CNT),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .table_valid       (table_valid_ff),
      .req_coil_index    (req_coil_index),
      .req_point_index   (req_point_index),
      .req_sensor_index  (req_sensor_index),
      .req_axis_index    (req_axis_index),
      .req_load_value    (req_load_value),
      .req_query_current (req_query_current),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_sensor    (rsp_out_sensor),
      .rsp_out_axis      (rsp_out_axis),
      .rsp_field_value   (rsp_field_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
`default_nettype wire

// File: rtl/core/cfti_checker.sv
`default_nettype none
module cfti_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_type,
   input wire logic       rsp_strobe,
   input wire logic [2:0] rsp_out_sensor,
   input wire logic [1:0] rsp_out_axis,
   input wire logic       rsp_last_of_run
);
   import cfti_pkg::*;

   // a query word takes the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_QUERY) |=> busy)
      else $error("query did not raise busy");

   // load words do not raise busy
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type != REQ_QUERY) |=> !busy)
      else $error("load word raised busy");

   // a run of results has no gaps
   a_run_dense: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |=> rsp_strobe)
      else $error("gap inside result run");

   // the last word is the final sensor and axis
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_run |->
         (rsp_out_sensor == 3'(SENSOR_CNT - 1)) && (rsp_out_axis == 2'(NUM_AXES - 1)))
      else $error("last word at wrong position");

   // runs do not abut
   a_run_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_run |=> !rsp_strobe)
      else $error("result after last word");

endmodule

bind coil_field_table_interpolator_top cfti_checker u_cfti_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_type        (req_type),
   .rsp_strobe      (rsp_strobe),
   .rsp_out_sensor  (rsp_out_sensor),
   .rsp_out_axis    (rsp_out_axis),
   .rsp_last_of_run (rsp_last_of_run)
);
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import cfti_pkg::*;

   localparam int          N_COILS   = 8;
   localparam int          N_POINTS  = 16;
   localparam logic [1:0]  REQ_NONE  = 2'd3;
   localparam int          SETTLE    = 100;
   localparam int          RAND_ITEMS = 60;

   // one stimulus word and one expected result word
   typedef struct {
      logic [1:0]         kind;
      logic [2:0]         coil;
      logic [3:0]         point;
      logic [2:0]         sensor;
      logic [1:0]         axis;
      logic signed [15:0] load;
      logic signed [15:0] cur;
      bit                 fixed;
      logic signed [15:0] fixed_val;
   } req_word_type;

   typedef struct {
      logic [2:0]         sensor;
      logic [1:0]         axis;
      logic signed [15:0] value;
      logic               last;
   } field_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]         req_type = '0;
   logic [2:0]         req_coil_index = '0;
   logic [3:0]         req_point_index = '0;
   logic [2:0]         req_sensor_index = '0;
   logic [1:0]         req_axis_index = '0;
   logic signed [15:0] req_load_value = '0;
   logic signed [15:0] req_query_current = '0;
   logic               rsp_strobe;
   logic [2:0]         rsp_out_sensor;
   logic [1:0]         rsp_out_axis;
   logic signed [15:0] rsp_field_value;
   logic               rsp_last_of_run;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   coil_field_table_interpolator_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_coil_index(req_coil_index),
      .req_point_index(req_point_index), .req_sensor_index(req_sensor_index),
      .req_axis_index(req_axis_index), .req_load_value(req_load_value),
      .req_query_current(req_query_current),
      .rsp_strobe(rsp_strobe), .rsp_out_sensor(rsp_out_sensor),
      .rsp_out_axis(rsp_out_axis), .rsp_field_value(rsp_field_value),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow of the calibration table and the valid flag
   logic signed [15:0] bp_shadow [N_POINTS];
   logic signed [15:0] fld_shadow [N_COILS*N_POINTS*VALS_PER_POINT];
   logic               valid_shadow = 1'b0;
   field_word_type     field_q [$];
   int                 errors = 0;
   int                 n_queries = 0;
   int                 n_loads = 0;
   int                 n_words = 0;

   function automatic int fld_idx(int c, int p, int s, int a);
      return ((c * N_POINTS + p) * SENSOR_CNT + s) * NUM_AXES + a;
   endfunction

   // table update and interpolation for one accepted word
   task automatic interpolate(input req_word_type w);
      longint cur, c0, cn, num, den, t, v0, v1, v;
      int idx, lo, hi, k;
      bit zero, lerp;
      field_word_type e;
      begin
         lo = 0; hi = 0; t = 0; lerp = 0; k = 0;
         if (w.kind == REQ_LOAD_POINT) begin
            bp_shadow[w.point] = w.load;
            n_loads++;
         end else if (w.kind == REQ_LOAD_FIELD) begin
            if (w.sensor < SENSOR_CNT && w.axis < NUM_AXES)
               fld_shadow[fld_idx(w.coil, w.point, w.sensor, w.axis)] = w.load;
            n_loads++;
         end else if (w.kind == REQ_QUERY) begin
            n_queries++;
            zero = !valid_shadow || (int'(w.coil) >= N_COILS);
            if (!zero) begin
               cur = w.cur;
               c0 = bp_shadow[0];
               cn = bp_shadow[N_POINTS-1];
               idx = 0;
               if (cur < c0) cur = c0;
               if (cur > cn) cur = cn;
               while (idx < N_POINTS - 1 && cur > longint'(bp_shadow[idx+1])) idx++;
               if (cur <= c0) begin
                  lo = 0;
               end else if (cur >= cn) begin
                  lo = N_POINTS - 1;
               end else begin
                  num = cur - longint'(bp_shadow[idx]);
                  den = longint'(bp_shadow[idx+1]) - longint'(bp_shadow[idx]);
                  if (num >= den) begin
                     lo = idx + 1;
                  end else begin
                     lo = idx;
                     hi = idx + 1;
                     t = (num * 65536) / den;
                     lerp = 1;
                  end
               end
            end
            for (int s = 0; s < SENSOR_CNT; s++) begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  v = 0;
                  if (!zero) begin
                     v0 = fld_shadow[fld_idx(w.coil, lo, s, a)];
                     v = v0;
                     if (lerp) begin
                        v1 = fld_shadow[fld_idx(w.coil, hi, s, a)];
                        v = v0 + ((t * (v1 - v0)) >>> 16);
                     end
                  end
                  e.sensor = 3'(s);
                  e.axis = 2'(a);
                  e.value = w.fixed ? w.fixed_val : v[15:0];
                  e.last = (k == VALS_PER_POINT - 1);
                  field_q.push_back(e);
                  k++;
               end
            end
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      field_word_type e;
      if (!reset && rsp_strobe) begin
         n_words++;
         if (field_q.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = field_q.pop_front();
            if (rsp_out_sensor !== e.sensor) begin
               $error("out_sensor exp %0d got %0d", e.sensor, rsp_out_sensor);
               errors++;
            end
            if (rsp_out_axis !== e.axis) begin
               $error("out_axis exp %0d got %0d", e.axis, rsp_out_axis);
               errors++;
            end
            if (rsp_field_value !== e.value) begin
               $error("field_value exp %0d got %0d", e.value, rsp_field_value);
               errors++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run exp %0d got %0d", e.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // drive one word: random gap, then hold start until accepted
   task automatic send(input req_word_type w);
      int gap;
      logic was_busy;
      begin
         gap = $urandom_range(0, 5);
         @(negedge clock);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
            @(negedge clock);
         end
         start = 1'b1;
         req_type = w.kind;
         req_coil_index = w.coil;
         req_point_index = w.point;
         req_sensor_index = w.sensor;
         req_axis_index = w.axis;
         req_load_value = w.load;
         req_query_current = w.cur;
         forever begin
            was_busy = busy;
            @(posedge clock);
            if (!was_busy) break;
            @(negedge clock);
         end
         interpolate(w);
      end
   endtask

   // wait for the block to drain, then write and read back table_valid
   task automatic write_valid(input logic val);
      begin
         @(negedge clock);
         start = 1'b0;
         wait (field_q.size() == 0);
         repeat (SETTLE) @(negedge clock);
         csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
         csr_paddr = 3'(4 * CSR_TABLE_VALID); csr_pwdata = {31'd0, val};
         @(negedge clock);
         csr_penable = 1'b1;
         @(negedge clock);
         csr_pwrite = 1'b0; csr_penable = 1'b0;
         @(negedge clock);
         csr_penable = 1'b1;
         @(posedge clock);
         if (csr_prdata[0] !== val) begin
            $error("table_valid readback exp %0d got %0d", val, csr_prdata[0]);
            errors++;
         end
         @(negedge clock);
         csr_psel = 1'b0; csr_penable = 1'b0;
         valid_shadow = val;
      end
   endtask

   function automatic req_word_type mk(logic [1:0] k, int c, int p, int s, int a,
                                       int lv, int cu);
      req_word_type w;
      w.kind = k; w.coil = 3'(c); w.point = 4'(p); w.sensor = 3'(s); w.axis = 2'(a);
      w.load = 16'(lv); w.cur = 16'(cu); w.fixed = 0; w.fixed_val = '0;
      return w;
   endfunction

   function automatic req_word_type mk_zero(int c, int cu);
      req_word_type w;
      w = mk(REQ_QUERY, c, 15, 7, 3, -1, cu);
      w.fixed = 1;
      return w;
   endfunction

   // random word; queries with a valid table only touch the loaded coil
   function automatic req_word_type rand_word();
      int r, c;
      req_word_type w;
      w = mk(REQ_NONE, $urandom_range(0, 7), $urandom_range(0, 15),
             $urandom_range(0, 7), $urandom_range(0, 3),
             $urandom_range(0, 65535), $urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 55) begin
         w.kind = REQ_QUERY;
         if (valid_shadow) w.coil = 3'd0;
         c = $urandom_range(0, 9);
         if (c == 0) w.cur = -16'sd32768;
         else if (c == 1) w.cur = 16'sd32767;
         else if (c < 5)
            w.cur = 16'(int'(bp_shadow[$urandom_range(0, 15)])
                        + int'($urandom_range(0, 4)) - 2);
      end else if (r < 80) begin
         w.kind = REQ_LOAD_FIELD;
         if ($urandom_range(0, 3) != 0) begin
            w.sensor = 3'($urandom_range(0, 4));
            w.axis = 2'($urandom_range(0, 2));
         end
      end else if (r < 92) begin
         w.kind = REQ_LOAD_POINT;
      end
      return w;
   endfunction

   req_word_type dir_tab [$];

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < N_POINTS; i++) bp_shadow[i] = '0;
      for (int i = 0; i < N_COILS*N_POINTS*VALS_PER_POINT; i++) fld_shadow[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // table not valid: zero results, ignored words
      dir_tab = '{mk_zero(0, -32768), mk_zero(7, 32767),
                  mk(REQ_NONE, 7, 15, 7, 3, 32767, -32768),
                  mk(REQ_LOAD_FIELD, 0, 0, 7, 0, 100, 0),
                  mk(REQ_LOAD_FIELD, 0, 0, 0, 3, 100, 0),
                  mk_zero(4, 0)};
      foreach (dir_tab[i]) send(dir_tab[i]);

      // load the breakpoints and the fields of coil 0
      for (int p = 0; p < N_POINTS; p++)
         send(mk(REQ_LOAD_POINT, $urandom_range(0, 7), p, 0, 0, -30000 + p*4000, 0));
      for (int p = 0; p < N_POINTS; p++)
         for (int s = 0; s < SENSOR_CNT; s++)
            for (int a = 0; a < NUM_AXES; a++)
               send(mk(REQ_LOAD_FIELD, 0, p, s, a, $urandom_range(0, 65535), 0));

      write_valid(1'b1);
      // clamps, exact breakpoint hits, midpoints, extreme field steps
      dir_tab = '{mk(REQ_QUERY, 0, 0, 0, 0, 0, -32768),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, 32767),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, -30000),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, 30000),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, -10000),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, -8000),
                  mk(REQ_LOAD_FIELD, 0, 0, 0, 0, -32768, 0),
                  mk(REQ_LOAD_FIELD, 0, 1, 0, 0, 32767, 0),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, -26001),
                  mk(REQ_LOAD_POINT, 0, 0, 0, 0, -32768, 0),
                  mk(REQ_LOAD_POINT, 0, 15, 0, 0, 32767, 0),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, -32767),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, 32766),
                  mk(REQ_LOAD_POINT, 0, 7, 0, 0, 32000, 0),
                  mk(REQ_QUERY, 0, 0, 0, 0, 0, 5000)};
      foreach (dir_tab[i]) send(dir_tab[i]);

      // random phases with the flag toggled between them
      for (int ph = 0; ph < 3; ph++) begin
         write_valid(ph != 1);
         for (int i = 0; i < RAND_ITEMS / 3; i++) send(rand_word());
      end
      write_valid(1'b0);

      @(negedge clock);
      start = 1'b0;
      wait (field_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d queries, %0d table loads, %0d result words checked.",
               n_queries, n_loads, n_words);
      if (errors == 0 && field_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
